// ===== hw/rtl/ldf_pkg.sv =====
// Shared types and constants of the length-prefixed frame deframer.
`default_nettype none
package ldf_pkg;

   localparam int HdrBytes      = 14;
   localparam int HdrCountWidth = 4;
   localparam int QueueDepth    = 4;

   localparam logic [31:0] MagicReset  = 32'h0000_0000;
   localparam logic [15:0] MaxLenReset = 16'd1024;

   typedef enum logic [1:0] {
      KIND_HEADER    = 2'd0,
      KIND_PAYLOAD   = 2'd1,
      KIND_BAD_MAGIC = 2'd2,
      KIND_TOO_LONG  = 2'd3
   } ldf_kind_type;

   typedef enum logic [0:0] {
      CSR_EXPECTED_MAGIC = 1'b0,
      CSR_MAX_LENGTH     = 1'b1
   } ldf_csr_type;

   typedef struct packed {
      logic         frame_end;
      ldf_kind_type kind;
      logic [7:0]   payload_byte;
      logic [15:0]  payload_length;
      logic [7:0]   frame_status;
      logic [7:0]   message_type;
      logic [31:0]  sequence_res;
      logic [7:0]   hdr_minor;
      logic [7:0]   hdr_major;
   } ldf_item_type;

   typedef struct packed {
      logic         valid;
      ldf_item_type item;
   } ldf_push_type;

endpackage
`default_nettype wire

// ===== hw/rtl/ldf_front.sv =====
// Header collection, frame checks and payload tracking of the deframer.
`default_nettype none
module ldf_front
   import ldf_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_we,
   input  wire logic [0:0]   csr_addr,
   input  wire logic [31:0]  csr_wdata,
   input  wire logic         byte_valid,
   input  wire logic [7:0]   byte_data,
   output ldf_push_type      push
);

   logic [31:0] magic_ff, magic_in;
   logic [15:0] max_len_ff, max_len_in;
   logic        in_payload_ff, in_payload_in;
   logic [HdrCountWidth-1:0] count_ff, count_in;
   logic [15:0] remaining_ff, remaining_in;
   logic [7:0]  hdr_ff [HdrBytes];

   logic        last_hdr;
   logic [7:0]  hdr13;
   logic [31:0] magic_seen;
   logic [15:0] len_seen;
   logic [15:0] rem_dec;

   assign last_hdr   = (count_ff == HdrCountWidth'(HdrBytes - 1));
   assign hdr13      = (!in_payload_ff && last_hdr) ? byte_data : hdr_ff[13];
   assign magic_seen = {hdr_ff[0], hdr_ff[1], hdr_ff[2], hdr_ff[3]};
   assign len_seen   = {hdr_ff[12], hdr13};
   assign rem_dec    = (remaining_ff != 16'd0) ? remaining_ff - 16'd1 : remaining_ff;

   always_comb begin
      magic_in      = magic_ff;
      max_len_in    = max_len_ff;
      in_payload_in = in_payload_ff;
      count_in      = count_ff;
      remaining_in  = remaining_ff;
      push.valid                = 1'b0;
      push.item.frame_end       = 1'b1;
      push.item.kind            = KIND_HEADER;
      push.item.payload_byte    = 8'd0;
      push.item.payload_length  = len_seen;
      push.item.frame_status    = hdr_ff[11];
      push.item.message_type    = hdr_ff[10];
      push.item.sequence_res    = {hdr_ff[6], hdr_ff[7], hdr_ff[8], hdr_ff[9]};
      push.item.hdr_minor       = hdr_ff[5];
      push.item.hdr_major       = hdr_ff[4];

      if (csr_we) begin
         unique case (ldf_csr_type'(csr_addr))
            CSR_EXPECTED_MAGIC: magic_in   = csr_wdata;
            CSR_MAX_LENGTH:     max_len_in = csr_wdata[15:0];
            default: ;
         endcase
      end

      if (byte_valid) begin
         if (in_payload_ff) begin
            remaining_in           = rem_dec;
            push.valid             = 1'b1;
            push.item.kind         = KIND_PAYLOAD;
            push.item.payload_byte = byte_data;
            push.item.frame_end    = (rem_dec == 16'd0);
            if (rem_dec == 16'd0) begin
               in_payload_in = 1'b0;
            end
         end else if (!last_hdr) begin
            count_in = count_ff + HdrCountWidth'(1);
         end else begin
            count_in   = '0;
            push.valid = 1'b1;
            priority if (magic_seen != magic_ff) begin
               push.item.kind = KIND_BAD_MAGIC;
            end else if (len_seen > max_len_ff) begin
               push.item.kind = KIND_TOO_LONG;
            end else begin
               push.item.kind      = KIND_HEADER;
               remaining_in        = len_seen;
               in_payload_in       = (len_seen != 16'd0);
               push.item.frame_end = (len_seen == 16'd0);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff      <= MagicReset;
         max_len_ff    <= MaxLenReset;
         in_payload_ff <= 1'b0;
         count_ff      <= '0;
         remaining_ff  <= 16'd0;
      end else begin
         magic_ff      <= magic_in;
         max_len_ff    <= max_len_in;
         in_payload_ff <= in_payload_in;
         count_ff      <= count_in;
         remaining_ff  <= remaining_in;
      end
   end

   always_ff @(posedge clock) begin
      if (byte_valid && !in_payload_ff) begin
         hdr_ff[count_ff] <= byte_data;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      in_payload_ff |-> (count_ff == '0))
      else $error("header count moved during payload");

   assert property (@(posedge clock) disable iff (reset)
      (byte_valid && !in_payload_ff && !last_hdr) |-> !push.valid)
      else $error("result pushed before header complete");

   assert property (@(posedge clock) disable iff (reset)
      (push.valid && push.item.kind != KIND_HEADER && push.item.kind != KIND_PAYLOAD)
      |=> (!in_payload_ff && count_ff == '0))
      else $error("no resync after header error");

endmodule
`default_nettype wire

// ===== hw/rtl/ldf_queue.sv =====
// Short result queue between the header front and the output side.
`default_nettype none
module ldf_queue
   import ldf_pkg::*;
#(
   parameter int Depth = QueueDepth
)(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire ldf_push_type push,
   output logic              full,
   output logic              out_valid,
   output ldf_item_type      out_item,
   input  wire logic         out_ready
);

   localparam int PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntWidth = $clog2(Depth + 1);

   ldf_item_type mem_ff [Depth];
   logic [PtrWidth-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CntWidth-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full      = (count_ff == CntWidth'(Depth));
   assign out_valid = (count_ff != '0);
   assign out_item  = mem_ff[rd_ff];
   assign do_push   = push.valid && !full;
   assign do_pop    = out_valid && out_ready;

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (wr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ff + PtrWidth'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ff + PtrWidth'(1);
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CntWidth'(1);
         2'b01:   count_in = count_ff - CntWidth'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push.item;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntWidth'(Depth))
      else $error("queue count overflow");

   assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !full)
      else $error("push into full queue");

   assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + CntWidth'(1)))
      else $error("queue count missed a push");

endmodule
`default_nettype wire

// ===== hw/rtl/length_prefixed_frame_deframer.sv =====
// Top level of the length-prefixed frame deframer.
//
// Accepts one stream byte per cycle on req_ and returns header, payload and
// error results on rsp_. A 14-byte big-endian header (magic, versions,
// sequence, type, status, length) is checked on its last byte against the
// magic and maximum-length registers; a failing header gives one error beat
// with tlast and the next byte starts a new header. A good header gives one
// header beat, then one beat per payload byte, tlast on the final one. The
// sustained rate is one byte per cycle while the queue is not full; each result
// is registered into a QDepth-entry queue on its way to rsp_, and req_tready
// falls only when that queue is full. No clearing pass after reset.
`default_nettype none
module length_prefixed_frame_deframer
   import ldf_pkg::*;
#(
   parameter int QDepth = QueueDepth
)(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_we,
   input  wire logic [0:0]   csr_addr,
   input  wire logic [31:0]  csr_wdata,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // data_byte
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // major version, minor version, sequence_res, message_type, frame_status,
   // payload_length, payload_byte
   output logic [87:0]       rsp_tdata,
   output logic [1:0]        rsp_tuser,   // kind
   output logic              rsp_tlast    // frame_end
);

   ldf_push_type push;
   ldf_item_type head;
   logic         full;

   assign req_tready = !full;

   ldf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .byte_valid (req_tvalid && !full),
      .byte_data  (req_tdata),
      .push       (push)
   );

   ldf_queue #(.Depth(QDepth)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .out_valid (rsp_tvalid),
      .out_item  (head),
      .out_ready (rsp_tready)
   );

   assign rsp_tdata = {head.payload_byte, head.payload_length, head.frame_status,
                       head.message_type, head.sequence_res, head.hdr_minor,
                       head.hdr_major};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.frame_end;

endmodule
`default_nettype wire

// ===== tb/length_prefixed_frame_deframer_tb.sv =====
// Self-checking testbench for the length-prefixed frame deframer: directed frames, then random.
`default_nettype none
module length_prefixed_frame_deframer_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ldf_pkg::*;

   localparam int WatchdogLimit = 2000;
   localparam int TailCycles    = 8;
   localparam int HoldOffCycles = 150;
   localparam int HoldOffFrame  = 12;
   localparam int RandomBytes   = 200;
   localparam int RandomPhases  = 5;
   localparam int PayloadAll    = 70000;
   localparam int PrintLimit    = 40;

   typedef struct packed {
      logic [31:0]  reg_magic;
      logic [15:0]  reg_max;
      logic [31:0]  magic;
      logic [7:0]   vmaj;
      logic [7:0]   vmin;
      logic [31:0]  seq;
      logic [7:0]   mtype;
      logic [7:0]   status;
      logic [15:0]  len;
      ldf_kind_type kind;
      logic         last;
   } frame_case_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        csr_we     = 1'b0;
   logic [0:0]  csr_addr   = CSR_EXPECTED_MAGIC;
   logic [31:0] csr_wdata  = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [87:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   // deframer state as predicted from the accepted bytes
   logic [31:0] magic_reg        = MagicReset;
   logic [15:0] max_len_reg      = MaxLenReset;
   logic        in_frame_payload = 1'b0;
   int          header_fill      = 0;
   logic [7:0]  header_bytes [HdrBytes];
   logic [15:0] payload_left     = '0;

   ldf_item_type awaited_beats [$];
   int           failures     = 0;
   int           bytes_sent   = 0;
   int           quiet_cycles = 0;
   int           send_calm    = 0;
   int           recv_calm    = 0;
   bit           hold_off     = 1'b0;

   length_prefixed_frame_deframer dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == WatchdogLimit) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic int idle_cycles(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm = $urandom_range(20, 80);
         return 0;
      end
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   function automatic ldf_item_type header_beat(ldf_kind_type k, logic [7:0] pb, logic fe);
      ldf_item_type it;
      it.kind           = k;
      it.hdr_major      = header_bytes[4];
      it.hdr_minor      = header_bytes[5];
      it.sequence_res   = {header_bytes[6], header_bytes[7], header_bytes[8], header_bytes[9]};
      it.message_type   = header_bytes[10];
      it.frame_status   = header_bytes[11];
      it.payload_length = {header_bytes[12], header_bytes[13]};
      it.payload_byte   = pb;
      it.frame_end      = fe;
      return it;
   endfunction

   function automatic bit deframe_step(input logic [7:0] b, output ldf_item_type beat);
      logic [15:0] len;
      beat = '0;
      if (in_frame_payload) begin
         if (payload_left != 0) payload_left--;
         if (payload_left == 0) in_frame_payload = 1'b0;
         beat = header_beat(KIND_PAYLOAD, b, payload_left == 0);
         return 1'b1;
      end
      header_bytes[header_fill] = b;
      header_fill++;
      if (header_fill < HdrBytes) return 1'b0;
      header_fill = 0;
      len = {header_bytes[12], header_bytes[13]};
      if ({header_bytes[0], header_bytes[1], header_bytes[2], header_bytes[3]} != magic_reg) begin
         beat = header_beat(KIND_BAD_MAGIC, 8'h00, 1'b1);
      end else if (len > max_len_reg) begin
         beat = header_beat(KIND_TOO_LONG, 8'h00, 1'b1);
      end else begin
         payload_left     = len;
         in_frame_payload = (len != 0);
         beat = header_beat(KIND_HEADER, 8'h00, len == 0);
      end
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (failures < PrintLimit) begin
         $display("mismatch %s: got %0h, want %0h at %0t", what, got, want, $realtime);
      end
      failures++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) report_mismatch(name, got, want);
   endtask

   task automatic send_byte(input logic [7:0] b, input bit typed, input ldf_item_type typed_beat);
      int gap;
      ldf_item_type beat;
      gap = idle_cycles(send_calm);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      if (deframe_step(b, beat)) awaited_beats.push_back(typed ? typed_beat : beat);
      bytes_sent++;
   endtask

   task automatic send_frame(input logic [31:0] magic, input logic [7:0] vmaj, input logic [7:0] vmin,
                             input logic [31:0] seq, input logic [7:0] mtype,
                             input logic [7:0] status, input logic [15:0] len,
                             input int header_cut, input int payload_cap,
                             input bit typed, input ldf_item_type typed_beat);
      logic [111:0] hdr;
      hdr = {magic, vmaj, vmin, seq, mtype, status, len};
      for (int i = 0; i < header_cut; i++) begin
         send_byte(hdr[111 - 8 * i -: 8], typed && i == HdrBytes - 1, typed_beat);
      end
      for (int n = 0; in_frame_payload && n < payload_cap; n++) begin
         send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
      end
   endtask

   task automatic realign();
      logic [7:0] pad;
      // pad a cut header with zeros so its length stays small
      while (in_frame_payload || header_fill != 0) begin
         pad = in_frame_payload ? 8'($urandom_range(0, 255)) : 8'h00;
         send_byte(pad, 1'b0, '0);
      end
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (awaited_beats.size() != 0) @(posedge clock);
      repeat (TailCycles) @(posedge clock);
   endtask

   task automatic write_regs(input logic [31:0] magic, input logic [15:0] max_len);
      settle();
      csr_we    <= 1'b1;
      csr_addr  <= CSR_EXPECTED_MAGIC;
      csr_wdata <= magic;
      @(posedge clock);
      magic_reg  = magic;
      csr_addr  <= CSR_MAX_LENGTH;
      csr_wdata <= {16'h0000, max_len};
      @(posedge clock);
      max_len_reg = max_len;
      csr_we     <= 1'b0;
   endtask

   initial begin : collect_results
      int stall;
      ldf_item_type got;
      ldf_item_type want;
      while (reset) @(posedge clock);
      forever begin
         if (hold_off) begin
            hold_off = 1'b0;
            stall = HoldOffCycles;
         end else begin
            stall = idle_cycles(recv_calm);
         end
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         got.hdr_major      = rsp_tdata[7:0];
         got.hdr_minor      = rsp_tdata[15:8];
         got.sequence_res   = rsp_tdata[47:16];
         got.message_type   = rsp_tdata[55:48];
         got.frame_status   = rsp_tdata[63:56];
         got.payload_length = rsp_tdata[79:64];
         got.payload_byte   = rsp_tdata[87:80];
         got.kind           = ldf_kind_type'(rsp_tuser);
         got.frame_end      = rsp_tlast;
         if (awaited_beats.size() == 0) begin
            report_mismatch("beat with nothing awaited, kind", got.kind, '0);
         end else begin
            want = awaited_beats.pop_front();
            check_field("kind", got.kind, want.kind);
            check_field("hdr_major", got.hdr_major, want.hdr_major);
            check_field("hdr_minor", got.hdr_minor, want.hdr_minor);
            check_field("sequence_res", got.sequence_res, want.sequence_res);
            check_field("message_type", got.message_type, want.message_type);
            check_field("frame_status", got.frame_status, want.frame_status);
            check_field("payload_length", got.payload_length, want.payload_length);
            check_field("payload_byte", got.payload_byte, want.payload_byte);
            check_field("frame_end", got.frame_end, want.frame_end);
         end
      end
   end

   initial begin : stimulus
      frame_case_type directed_frames [13];
      frame_case_type fc;
      ldf_item_type   want;
      logic [31:0]    magic;
      logic [15:0]    len;
      int             pick;
      int             cap;
      int             wide;
      int             phase_end;

      foreach (header_bytes[i]) header_bytes[i] = 8'h00;

      //                   reg_magic     reg_max  magic         vmaj   vmin   seq
      //                   mtype  status len       kind            last
      directed_frames[0]  = '{32'h0000_0000, 16'd1024, 32'h0000_0000, 8'h00, 8'h00, 32'h0000_0000,
                              8'h00, 8'h00, 16'd0,    KIND_HEADER,    1'b1};
      directed_frames[1]  = '{32'h0000_0000, 16'd1024, 32'h0000_0000, 8'hFF, 8'hFF, 32'hFFFF_FFFF,
                              8'hFF, 8'hFF, 16'd3,    KIND_HEADER,    1'b0};
      directed_frames[2]  = '{32'h0000_0000, 16'd1024, 32'h0000_0000, 8'h01, 8'h02, 32'h1234_5678,
                              8'h9A, 8'hBC, 16'd5,    KIND_HEADER,    1'b0};
      directed_frames[3]  = '{32'h0000_0000, 16'd1024, 32'h0000_0000, 8'h11, 8'h22, 32'h8765_4321,
                              8'h33, 8'h44, 16'd1025, KIND_TOO_LONG,  1'b1};
      directed_frames[4]  = '{32'h0000_0000, 16'd1024, 32'hFFFF_FFFF, 8'h55, 8'hAA, 32'h0F0F_0F0F,
                              8'h5A, 8'hA5, 16'd0,    KIND_BAD_MAGIC, 1'b1};
      directed_frames[5]  = '{32'h0000_0000, 16'd1024, 32'h8000_0000, 8'h80, 8'h7F, 32'h8000_0001,
                              8'h01, 8'h80, 16'hFFFF, KIND_BAD_MAGIC, 1'b1};
      directed_frames[6]  = '{32'h0000_0000, 16'd1024, 32'h0000_0000, 8'h00, 8'h01, 32'hDEAD_0001,
                              8'h02, 8'h03, 16'hFFFF, KIND_TOO_LONG,  1'b1};
      directed_frames[7]  = '{32'hFFFF_FFFF, 16'd0,    32'hFFFF_FFFF, 8'hC3, 8'h3C, 32'h0000_0001,
                              8'h04, 8'h05, 16'd0,    KIND_HEADER,    1'b1};
      directed_frames[8]  = '{32'hFFFF_FFFF, 16'd0,    32'hFFFF_FFFF, 8'h06, 8'h07, 32'h0000_0002,
                              8'h08, 8'h09, 16'd1,    KIND_TOO_LONG,  1'b1};
      directed_frames[9]  = '{32'hFFFF_FFFF, 16'd0,    32'h0000_0000, 8'h0A, 8'h0B, 32'h0000_0003,
                              8'h0C, 8'h0D, 16'd0,    KIND_BAD_MAGIC, 1'b1};
      directed_frames[10] = '{32'hA5C3_0F96, 16'hFFFF, 32'hA5C3_0F96, 8'h10, 8'h20, 32'hCAFE_F00D,
                              8'h30, 8'h40, 16'd1,    KIND_HEADER,    1'b0};
      directed_frames[11] = '{32'hA5C3_0F96, 16'hFFFF, 32'hA5C3_0F97, 8'h50, 8'h60, 32'h7FFF_FFFF,
                              8'h70, 8'hFE, 16'd2,    KIND_BAD_MAGIC, 1'b1};
      directed_frames[12] = '{32'hA5C3_0F96, 16'd16,   32'hA5C3_0F96, 8'hEF, 8'hBE, 32'hFEED_BEEF,
                              8'hAD, 8'hDE, 16'd16,   KIND_HEADER,    1'b0};

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < 13; i++) begin
         fc = directed_frames[i];
         if (fc.reg_magic !== magic_reg || fc.reg_max !== max_len_reg) begin
            write_regs(fc.reg_magic, fc.reg_max);
         end
         // hold the receiver off so the result queue fills and req_tready drops
         if (i == HoldOffFrame) hold_off = 1'b1;
         want.kind           = fc.kind;
         want.hdr_major      = fc.vmaj;
         want.hdr_minor      = fc.vmin;
         want.sequence_res   = fc.seq;
         want.message_type   = fc.mtype;
         want.frame_status   = fc.status;
         want.payload_length = fc.len;
         want.payload_byte   = 8'h00;
         want.frame_end      = fc.last;
         send_frame(fc.magic, fc.vmaj, fc.vmin, fc.seq, fc.mtype, fc.status, fc.len,
                    HdrBytes, PayloadAll, 1'b1, want);
      end

      for (int phase = 0; phase < RandomPhases; phase++) begin
         case (phase)
            0: write_regs($urandom, 16'($urandom_range(0, 48)));
            1: write_regs(32'hFFFF_FFFF, 16'hFFFF);
            2: write_regs(32'h0000_0000, 16'h0000);
            3: write_regs($urandom, 16'($urandom_range(0, 65535)));
            default: write_regs($urandom, 16'($urandom_range(1, 12)));
         endcase
         phase_end = bytes_sent + RandomBytes / RandomPhases;
         while (bytes_sent < phase_end) begin
            pick  = $urandom_range(0, 99);
            magic = magic_reg;
            cap   = (max_len_reg < 12) ? max_len_reg : 12;
            if ($urandom_range(0, 7) == 0) cap = (max_len_reg < 64) ? max_len_reg : 64;
            len = 16'($urandom_range(0, cap));
            if (pick < 8 && max_len_reg <= 64) len = max_len_reg;
            if (pick >= 60 && pick < 72) begin
               if ($urandom_range(0, 1) == 0) magic = magic ^ (32'h1 << $urandom_range(0, 31));
               else magic = $urandom;
            end else if (pick >= 72 && pick < 84 && max_len_reg != 16'hFFFF) begin
               wide = max_len_reg + 1 + $urandom_range(0, 7);
               if (wide > 65535 || $urandom_range(0, 3) == 0) wide = 65535;
               len = 16'(wide);
            end
            if (pick < 84) begin
               realign();
               send_frame(magic, 8'($urandom), 8'($urandom), $urandom, 8'($urandom),
                          8'($urandom), len, HdrBytes, PayloadAll, 1'b0, '0);
            end else if (pick < 92) begin
               repeat ($urandom_range(1, 20)) send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
            end else if ($urandom_range(0, 1) == 0) begin
               realign();
               send_frame(magic, 8'($urandom), 8'($urandom), $urandom, 8'($urandom),
                          8'($urandom), len, $urandom_range(1, HdrBytes - 1), 0, 1'b0, '0);
            end else begin
               realign();
               send_frame(magic, 8'($urandom), 8'($urandom), $urandom, 8'($urandom),
                          8'($urandom), len, HdrBytes, (len > 0) ? $urandom_range(0, len - 1) : 0,
                          1'b0, '0);
            end
         end
      end

      settle();
      if (failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire
